// ===== rtl/qte_pkg.sv =====
`timescale 1ns / 1ps

package qte_pkg;

    // Field widths
    localparam int QW       = 16;  // quaternion component
    localparam int PROD_W   = 32;  // 16 x 16 product
    localparam int SUM_W    = 34;  // doubled sum of two products
    localparam int SQ_W     = 32;  // asin argument with 30 fraction bits
    localparam int SQR_W    = 61;  // radicand 2^60 - sq^2
    localparam int ROOT_W   = 32;  // square root result
    localparam int CIN_W    = 36;  // CORDIC operand at entry
    localparam int CW       = 45;  // CORDIC working width
    localparam int ZW       = 35;  // angle accumulator, 30 fraction bits
    localparam int ANG_W    = 16;  // roll and yaw field
    localparam int PITCH_W  = 15;  // pitch field

    // Numeric constants
    localparam int INPUT_FRAC_BITS = 14;
    localparam int ANGLE_FRAC_BITS = 13;
    localparam int ANG_FRAC        = 30;
    localparam int CORDIC_STAGES   = 16;
    localparam int NORM_TOP        = 41;  // normalized magnitude lies below 2^NORM_TOP
    localparam int NORM_STEPS      = 6;   // shifts of 32, 16, 8, 4, 2, 1
    localparam int NORM_REGS       = 3;   // two shift steps per register stage
    localparam int ISQ_ITER        = 31;  // one root bit per stage
    localparam int RND_SHIFT       = ANG_FRAC - ANGLE_FRAC_BITS;

    // Latencies in register stages
    localparam int PROD_LAT = 2;
    localparam int ISQ_LAT  = 1 + ISQ_ITER;
    localparam int COR_LAT  = 1 + NORM_REGS + CORDIC_STAGES + 1;
    localparam int PIPE_LAT = PROD_LAT + ISQ_LAT + COR_LAT;

    localparam logic signed [ZW-1:0] PI_Q30      = 35'sd3373259426;
    localparam logic signed [ZW-1:0] HALF_PI_Q30 = 35'sd1686629713;

    typedef struct packed {
        logic signed [CW-1:0] x;
        logic signed [CW-1:0] y;
    } vec_t;

    typedef struct packed {
        logic signed [SUM_W-1:0] rn;
        logic signed [SUM_W-1:0] rd;
        logic signed [SUM_W-1:0] yn;
        logic signed [SUM_W-1:0] yd;
        logic                    sat;
    } ry_t;

    // Arctangent of 2^-i with 30 fraction bits, truncated through i = 26 and rounded beyond
    function automatic logic signed [ZW-1:0] atan_entry(input int i);
        logic [31:0] v;
        case (i)
            0:  v = 32'h3243F6A8;
            1:  v = 32'h1DAC6705;
            2:  v = 32'h0FADBAFC;
            3:  v = 32'h07F56EA6;
            4:  v = 32'h03FEAB76;
            5:  v = 32'h01FFD55B;
            6:  v = 32'h00FFFAAA;
            7:  v = 32'h007FFF55;
            8:  v = 32'h003FFFEA;
            9:  v = 32'h001FFFFD;
            10: v = 32'h000FFFFF;
            11: v = 32'h0007FFFF;
            12: v = 32'h0003FFFF;
            13: v = 32'h0001FFFF;
            14: v = 32'h0000FFFF;
            15: v = 32'h00007FFF;
            16: v = 32'h00003FFF;
            17: v = 32'h00001FFF;
            18: v = 32'h00000FFF;
            19: v = 32'h000007FF;
            20: v = 32'h000003FF;
            21: v = 32'h000001FF;
            22: v = 32'h000000FF;
            23: v = 32'h0000007F;
            24: v = 32'h0000003F;
            25: v = 32'h0000001F;
            26: v = 32'h0000000F;
            27: v = 32'h00000008;
            28: v = 32'h00000004;
            29: v = 32'h00000002;
            30: v = 32'h00000001;
            default: v = 32'h00000000;
        endcase
        return $signed({{(ZW-32){1'b0}}, v});
    endfunction

    // One normalize step: shift left by k when the result stays below 2^NORM_TOP
    function automatic vec_t norm_step(input vec_t v, input int k);
        logic [CW-1:0] mx;
        logic [CW-1:0] my;
        logic [CW-1:0] lim;
        vec_t          r;
        mx  = v.x[CW-1] ? $unsigned(-v.x) : $unsigned(v.x);
        my  = v.y[CW-1] ? $unsigned(-v.y) : $unsigned(v.y);
        lim = {{(CW-1){1'b0}}, 1'b1} << (NORM_TOP - k);
        r   = v;
        if ((mx | my) < lim)
        begin
            r.x = v.x <<< k;
            r.y = v.y <<< k;
        end
        return r;
    endfunction

endpackage

// ===== rtl/qte_products.sv =====
`timescale 1ns / 1ps

module qte_products
    import qte_pkg::*;
(
    input  logic                    clk,
    input  logic                    en,
    input  logic signed [QW-1:0]    qw,
    input  logic signed [QW-1:0]    qx,
    input  logic signed [QW-1:0]    qy,
    input  logic signed [QW-1:0]    qz,
    output ry_t                     ry,
    output logic signed [SQ_W-1:0]  sq
);

    localparam logic signed [SUM_W-1:0] ONE   = SUM_W'(1) <<< (2 * INPUT_FRAC_BITS);
    localparam int                      SQ_SH = ANG_FRAC - 2 * INPUT_FRAC_BITS;

    logic signed [PROD_W-1:0] wx_reg, yz_reg, xx_reg, yy_reg, wz_reg;
    logic signed [PROD_W-1:0] xy_reg, zz_reg, wy_reg, xz_reg;
    ry_t                      ry_reg;
    logic signed [SQ_W-1:0]   sq_reg;

    logic signed [SUM_W-1:0]  s_next;
    logic signed [SUM_W-1:0]  s_cl;
    logic                     sat_next;

    // Form all products
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            wx_reg <= qw * qx;
            yz_reg <= qy * qz;
            xx_reg <= qx * qx;
            yy_reg <= qy * qy;
            wz_reg <= qw * qz;
            xy_reg <= qx * qy;
            zz_reg <= qz * qz;
            wy_reg <= qw * qy;
            xz_reg <= qx * qz;
        end
    end

    // Clamp the asin argument to unit magnitude
    always_comb
    begin
        s_next   = 2 * (SUM_W'(wy_reg) - SUM_W'(xz_reg));
        s_cl     = s_next;
        sat_next = 1'b0;
        if (s_next > ONE)
        begin
            s_cl     = ONE;
            sat_next = 1'b1;
        end
        else if (s_next < -ONE)
        begin
            s_cl     = -ONE;
            sat_next = 1'b1;
        end
    end

    // Combine products into atan2 operands
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            ry_reg.rn  <= 2 * (SUM_W'(wx_reg) + SUM_W'(yz_reg));
            ry_reg.rd  <= ONE - 2 * (SUM_W'(xx_reg) + SUM_W'(yy_reg));
            ry_reg.yn  <= 2 * (SUM_W'(wz_reg) + SUM_W'(xy_reg));
            ry_reg.yd  <= ONE - 2 * (SUM_W'(yy_reg) + SUM_W'(zz_reg));
            ry_reg.sat <= sat_next;
            sq_reg     <= SQ_W'(s_cl <<< SQ_SH);
        end
    end

    assign ry = ry_reg;
    assign sq = sq_reg;

endmodule

// ===== rtl/qte_isqrt.sv =====
`timescale 1ns / 1ps

module qte_isqrt
    import qte_pkg::*;
(
    input  logic                   clk,
    input  logic                   en,
    input  logic signed [SQ_W-1:0] sq,
    output logic [ROOT_W-1:0]      root
);

    localparam logic [SQR_W:0] FULL = (SQR_W+1)'(1) << (2 * ANG_FRAC);

    logic [SQR_W-1:0]         rem_reg [0:ISQ_ITER];
    logic [SQR_W-1:0]         res_reg [0:ISQ_ITER];
    logic signed [2*SQ_W-1:0] sqq;

    // Radicand 1 - sq^2
    assign sqq = sq * sq;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            rem_reg[0] <= SQR_W'(FULL - sqq[SQR_W:0]);
            res_reg[0] <= '0;
        end
    end

    // One root bit per stage, from the top bit down
    for (genvar j = 0; j < ISQ_ITER; j++)
    begin : g_iter
        localparam int            I   = ISQ_ITER - 1 - j;
        localparam logic [SQR_W:0] BIT = (SQR_W+1)'(1) << (2 * I);

        logic [SQR_W:0] trial;
        assign trial = {1'b0, res_reg[j]} + BIT;

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                if ({1'b0, rem_reg[j]} >= trial)
                begin
                    rem_reg[j+1] <= SQR_W'({1'b0, rem_reg[j]} - trial);
                    res_reg[j+1] <= (res_reg[j] >> 1) + SQR_W'(BIT);
                end
                else
                begin
                    rem_reg[j+1] <= rem_reg[j];
                    res_reg[j+1] <= res_reg[j] >> 1;
                end
            end
        end
    end

    assign root = res_reg[ISQ_ITER][ROOT_W-1:0];

endmodule

// ===== rtl/qte_cordic.sv =====
`timescale 1ns / 1ps

module qte_cordic
    import qte_pkg::*;
(
    input  logic                    clk,
    input  logic                    en,
    input  logic signed [CIN_W-1:0] num,
    input  logic signed [CIN_W-1:0] den,
    input  logic signed [ZW-1:0]    lim,
    output logic [ANG_W-1:0]        angle
);

    localparam int LAST = NORM_REGS + CORDIC_STAGES;

    vec_t                 v_reg    [0:LAST];
    logic signed [ZW-1:0] z_reg    [0:LAST];
    logic                 zero_reg [0:LAST];
    logic [ANG_W-1:0]     angle_reg;

    logic signed [CW-1:0] nx, ny;
    logic signed [ZW-1:0] zc;
    logic signed [ZW-1:0] zr;

    assign nx = CW'(num);
    assign ny = CW'(den);

    // Fold the left half plane into the right one
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            zero_reg[0] <= (num == '0) && (den == '0);
            if (den < 0)
            begin
                z_reg[0]   <= (num >= 0) ? PI_Q30 : -PI_Q30;
                v_reg[0].x <= -ny;
                v_reg[0].y <= -nx;
            end
            else
            begin
                z_reg[0]   <= '0;
                v_reg[0].x <= ny;
                v_reg[0].y <= nx;
            end
        end
    end

    // Normalize by powers of two, two steps per stage
    for (genvar n = 0; n < NORM_REGS; n++)
    begin : g_norm
        vec_t a;
        vec_t b;
        assign a = norm_step(v_reg[n], 32 >> (2 * n));
        assign b = norm_step(a, 32 >> (2 * n + 1));

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                v_reg[n+1]    <= b;
                z_reg[n+1]    <= z_reg[n];
                zero_reg[n+1] <= zero_reg[n];
            end
        end
    end

    // Vectoring iterations, one per stage
    for (genvar i = 0; i < CORDIC_STAGES; i++)
    begin : g_iter
        localparam int K = NORM_REGS + i;
        logic signed [CW-1:0] xs, ys;
        assign xs = v_reg[K].x >>> i;
        assign ys = v_reg[K].y >>> i;

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                zero_reg[K+1] <= zero_reg[K];
                if (v_reg[K].y < 0)
                begin
                    v_reg[K+1].x <= v_reg[K].x - ys;
                    v_reg[K+1].y <= v_reg[K].y + xs;
                    z_reg[K+1]   <= z_reg[K] - atan_entry(i);
                end
                else
                begin
                    v_reg[K+1].x <= v_reg[K].x + ys;
                    v_reg[K+1].y <= v_reg[K].y - xs;
                    z_reg[K+1]   <= z_reg[K] + atan_entry(i);
                end
            end
        end
    end

    // Clamp and round half up to the output format
    always_comb
    begin
        zc = z_reg[LAST];
        if (zc > lim)
        begin
            zc = lim;
        end
        else if (zc < -lim)
        begin
            zc = -lim;
        end
        zr = (zc + (ZW'(1) <<< (RND_SHIFT - 1))) >>> RND_SHIFT;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            angle_reg <= zero_reg[LAST] ? '0 : zr[ANG_W-1:0];
        end
    end

    assign angle = angle_reg;

endmodule

// ===== rtl/quaternion_to_euler_angles.sv =====
`timescale 1ns / 1ps

// Converts one w-first Q2.14 quaternion per transaction into Z-Y-X roll, pitch
// and yaw in radians (roll and yaw Q3.13, pitch Q2.13), with a flag when the
// asin argument was clamped. It takes a new quaternion in every cycle it is not
// halted and returns each result after 2 product stages, 32 square-root stages
// for the pitch cosine and 21 CORDIC stages, plus the output register. The
// pipeline halts only when output register and skid stage both hold results.
module quaternion_to_euler_angles
    import qte_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [63:0] s_axis_tdata,   // quat_w, quat_x, quat_y, quat_z
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [47:0] m_axis_tdata,   // roll_angle, pitch_angle, yaw_angle, zero pad
    output logic        m_axis_tuser    // pitch_saturated
);

    logic                  en;
    logic                  valid_reg [0:PIPE_LAT-1];
    ry_t                   ry;
    ry_t                   ry_dly_reg [0:ISQ_LAT-1];
    logic                  sat_dly_reg [0:COR_LAT-1];
    logic signed [SQ_W-1:0] sq;
    logic signed [SQ_W-1:0] sq_dly_reg [0:ISQ_LAT-1];
    logic [ROOT_W-1:0]     root;
    logic [ANG_W-1:0]      roll, pitch, yaw;

    logic                  out_valid_reg, skid_valid_reg;
    logic [47:0]           out_data_reg, skid_data_reg;
    logic                  out_user_reg, skid_user_reg;
    logic [47:0]           pipe_data;
    logic                  pipe_user;
    logic                  out_free;

    assign en            = !skid_valid_reg;
    assign s_axis_tready = en;

    qte_products u_products (
        .clk (clk),
        .en  (en),
        .qw  (s_axis_tdata[15:0]),
        .qx  (s_axis_tdata[31:16]),
        .qy  (s_axis_tdata[47:32]),
        .qz  (s_axis_tdata[63:48]),
        .ry  (ry),
        .sq  (sq)
    );

    qte_isqrt u_isqrt (
        .clk  (clk),
        .en   (en),
        .sq   (sq),
        .root (root)
    );

    // Hold roll and yaw operands while the root settles, and carry the clamp flag alongside
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            ry_dly_reg[0] <= ry;
            for (int i = 1; i < ISQ_LAT; i++)
            begin
                ry_dly_reg[i] <= ry_dly_reg[i-1];
            end
            sat_dly_reg[0] <= ry_dly_reg[ISQ_LAT-1].sat;
            for (int i = 1; i < COR_LAT; i++)
            begin
                sat_dly_reg[i] <= sat_dly_reg[i-1];
            end
        end
    end

    // Delay the asin argument alongside the root
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            sq_dly_reg[0] <= sq;
            for (int i = 1; i < ISQ_LAT; i++)
            begin
                sq_dly_reg[i] <= sq_dly_reg[i-1];
            end
        end
    end

    qte_cordic u_roll (
        .clk   (clk),
        .en    (en),
        .num   (CIN_W'(ry_dly_reg[ISQ_LAT-1].rn)),
        .den   (CIN_W'(ry_dly_reg[ISQ_LAT-1].rd)),
        .lim   (PI_Q30),
        .angle (roll)
    );

    qte_cordic u_pitch (
        .clk   (clk),
        .en    (en),
        .num   (CIN_W'(sq_dly_reg[ISQ_LAT-1])),
        .den   ($signed({{(CIN_W-ROOT_W){1'b0}}, root})),
        .lim   (HALF_PI_Q30),
        .angle (pitch)
    );

    qte_cordic u_yaw (
        .clk   (clk),
        .en    (en),
        .num   (CIN_W'(ry_dly_reg[ISQ_LAT-1].yn)),
        .den   (CIN_W'(ry_dly_reg[ISQ_LAT-1].yd)),
        .lim   (PI_Q30),
        .angle (yaw)
    );

    // Advance valid bits with the data
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < PIPE_LAT; i++)
            begin
                valid_reg[i] <= 1'b0;
            end
        end
        else if (en)
        begin
            valid_reg[0] <= s_axis_tvalid;
            for (int i = 1; i < PIPE_LAT; i++)
            begin
                valid_reg[i] <= valid_reg[i-1];
            end
        end
    end

    assign pipe_data = {1'b0, yaw, pitch[PITCH_W-1:0], roll};
    assign pipe_user = sat_dly_reg[COR_LAT-1];
    assign out_free  = !out_valid_reg || m_axis_tready;

    // Output register with skid stage
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else
        begin
            if (en && valid_reg[PIPE_LAT-1])
            begin
                if (out_free)
                begin
                    out_valid_reg <= 1'b1;
                end
                else
                begin
                    skid_valid_reg <= 1'b1;
                end
            end
            else if (skid_valid_reg && out_free)
            begin
                out_valid_reg  <= 1'b1;
                skid_valid_reg <= 1'b0;
            end
            else if (m_axis_tready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (en && valid_reg[PIPE_LAT-1])
        begin
            if (out_free)
            begin
                out_data_reg <= pipe_data;
                out_user_reg <= pipe_user;
            end
            else
            begin
                skid_data_reg <= pipe_data;
                skid_user_reg <= pipe_user;
            end
        end
        else if (skid_valid_reg && out_free)
        begin
            out_data_reg <= skid_data_reg;
            out_user_reg <= skid_user_reg;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_data_reg;
    assign m_axis_tuser  = out_user_reg;

endmodule
